### src/lrr_pkg.sv
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared widths, codes and types of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lrr_pkg;

  localparam int LANES       = 4;
  localparam int SAMPLE_W    = 24;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int FRAC_W      = 24;
  localparam int STEP_W      = 29;
  localparam int PHASE_W     = STEP_W + 1;
  localparam int PROD_W      = DIFF_W + FRAC_W + 1;
  localparam int CHAN_W      = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = STEP_W;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_W;
  localparam logic [STEP_W-1:0]  STEP_ONE  = STEP_W'(1) << FRAC_W;

  localparam logic [STEP_W-1:0] RATE_STEP_RST       = STEP_ONE;
  localparam logic [CHAN_W-1:0] ACTIVE_CHANNELS_RST = CHAN_W'(2);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 1'b1;

  typedef logic signed [SAMPLE_W-1:0]   sample_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic [LANES-1:0][SAMPLE_W-1:0] frame_t;

  typedef enum logic {
    CMD_INTERP,
    CMD_BYPASS
  } cmd_kind_t;

  // One queued word: the previous and the new source frame
  typedef struct packed {
    cmd_kind_t kind;
    frame_t    a;
    frame_t    b;
  } cmd_t;

  // One output position handed to the datapath
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [FRAC_W-1:0] frac;
  } issue_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

### src/lrr_front.sv
// ----------------------------------------------------------------------------
// lrr_front
// Accepts source frames, keeps the previous frame and classifies each word.
// ----------------------------------------------------------------------------
module lrr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lrr_pkg::frame_t             in_frame,
  input  logic [lrr_pkg::STEP_W-1:0]  rate_step,
  input  logic                        q_full,
  output logic                        q_push,
  output lrr_pkg::cmd_t               q_cmd
);

  lrr_pkg::frame_t prev_r, prev_nxt;
  logic            primed_r, primed_nxt;
  logic            acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  always_comb begin
    prev_nxt    = prev_r;
    primed_nxt  = primed_r;
    q_push      = 1'b0;
    q_cmd.kind  = lrr_pkg::CMD_INTERP;
    q_cmd.a     = prev_r;
    q_cmd.b     = in_frame;
    if (acc) begin
      prev_nxt   = in_frame;
      primed_nxt = 1'b1;
      if (rate_step == lrr_pkg::STEP_ONE) begin
        q_push     = 1'b1;
        q_cmd.kind = lrr_pkg::CMD_BYPASS;
      end else if (primed_r) begin
        q_push = 1'b1;
      end
      // otherwise: priming frame, store only
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
    end else begin
      primed_r <= primed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
  end

endmodule

### src/lrr_queue.sv
// ----------------------------------------------------------------------------
// lrr_queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lrr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lrr_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output lrr_pkg::cmd_t rdata,
  output logic          empty
);

  localparam int PTR_W = (lrr_pkg::QUEUE_DEPTH > 1) ? $clog2(lrr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(lrr_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(lrr_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(lrr_pkg::QUEUE_DEPTH);

  lrr_pkg::cmd_t    mem_r [lrr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### src/lrr_back.sv
// ----------------------------------------------------------------------------
// lrr_back
// Sequencer: steps the read phase, issues one position per cycle unless held.
// ----------------------------------------------------------------------------
module lrr_back #(
  parameter int MAX_OUTPUTS_PER_INPUT = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  lrr_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  input  logic [lrr_pkg::STEP_W-1:0]  rate_step,
  input  logic                        adv,
  output lrr_pkg::issue_t             issue,
  output lrr_pkg::frame_t             op_a,
  output lrr_pkg::diff_t              op_diff [lrr_pkg::LANES]
);

  localparam int CNT_W = (MAX_OUTPUTS_PER_INPUT > 1) ? $clog2(MAX_OUTPUTS_PER_INPUT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OUTPUTS_PER_INPUT - 1);

  lrr_pkg::back_state_t         state_r, state_nxt;
  logic [lrr_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         bypass_r, bypass_nxt;
  lrr_pkg::frame_t              a_r, a_nxt;
  lrr_pkg::diff_t               diff_r [lrr_pkg::LANES];
  lrr_pkg::diff_t               diff_nxt [lrr_pkg::LANES];
  logic [lrr_pkg::PHASE_W-1:0]  sum;

  assign op_a    = a_r;
  assign op_diff = diff_r;
  assign sum     = phase_r + lrr_pkg::PHASE_W'(rate_step);

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    bypass_nxt = bypass_r;
    a_nxt      = a_r;
    diff_nxt   = diff_r;
    q_pop      = 1'b0;
    issue.vld  = 1'b0;
    issue.last = 1'b0;
    issue.frac = phase_r[lrr_pkg::FRAC_W-1:0];
    unique case (state_r)
      lrr_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = lrr_pkg::BK_RUN;
          bypass_nxt = (q_cmd.kind == lrr_pkg::CMD_BYPASS);
          // bypass runs through the same datapath with a zero slope
          a_nxt      = bypass_nxt ? q_cmd.b : q_cmd.a;
          for (int i = 0; i < lrr_pkg::LANES; i++) begin
            if (bypass_nxt) begin
              diff_nxt[i] = '0;
            end else begin
              diff_nxt[i] = lrr_pkg::DIFF_W'(lrr_pkg::sample_t'(q_cmd.b[i]))
                          - lrr_pkg::DIFF_W'(lrr_pkg::sample_t'(q_cmd.a[i]));
            end
          end
        end
      end
      lrr_pkg::BK_RUN: begin
        if (bypass_r) begin
          if (adv) begin
            issue.vld  = 1'b1;
            issue.last = 1'b1;
            issue.frac = '0;
            state_nxt  = lrr_pkg::BK_IDLE;
          end
        end else if (phase_r >= lrr_pkg::PHASE_ONE) begin
          // no output position left in this source interval
          phase_nxt = phase_r - lrr_pkg::PHASE_ONE;
          state_nxt = lrr_pkg::BK_IDLE;
        end else if (adv) begin
          issue.vld  = 1'b1;
          issue.last = (sum >= lrr_pkg::PHASE_ONE) || (cnt_r == CNT_LAST);
          if (issue.last) begin
            phase_nxt = (sum >= lrr_pkg::PHASE_ONE) ? sum - lrr_pkg::PHASE_ONE : '0;
            state_nxt = lrr_pkg::BK_IDLE;
          end else begin
            phase_nxt = sum;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = lrr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrr_pkg::BK_IDLE;
      phase_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bypass_r <= bypass_nxt;
    a_r      <= a_nxt;
    diff_r   <= diff_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lrr_pkg::BK_RUN |-> cnt_r <= CNT_LAST)
    else $error("output counter ran past the per-frame limit");

  a_issue_adv: assert property (@(posedge clk) disable iff (!rst_n)
    issue.vld |-> adv)
    else $error("position issued while the datapath is held");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    issue.vld && issue.last |=> state_r == lrr_pkg::BK_IDLE)
    else $error("sequencer kept running after the final position");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == lrr_pkg::BK_IDLE && !q_empty)
    else $error("queue popped outside idle or while empty");

endmodule

### src/lrr_lerp.sv
// ----------------------------------------------------------------------------
// lrr_lerp
// Two-stage interpolation datapath: multiply register, then output register.
// ----------------------------------------------------------------------------
module lrr_lerp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lrr_pkg::issue_t             issue,
  input  lrr_pkg::frame_t             op_a,
  input  lrr_pkg::diff_t              op_diff [lrr_pkg::LANES],
  input  logic [lrr_pkg::CHAN_W-1:0]  active_channels,
  output logic                        adv,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lrr_pkg::frame_t             out_frame,
  output logic                        out_last
);

  logic                              s1_vld_r;
  logic                              s1_last_r;
  lrr_pkg::frame_t                   s1_a_r;
  logic signed [lrr_pkg::PROD_W-1:0] s1_prod_r [lrr_pkg::LANES];
  logic signed [lrr_pkg::PROD_W-1:0] prod_c [lrr_pkg::LANES];
  lrr_pkg::diff_t                    term_c [lrr_pkg::LANES];
  lrr_pkg::diff_t                    sum_c [lrr_pkg::LANES];
  lrr_pkg::frame_t                   res_c;
  logic                              out_valid_r;
  logic                              out_last_r;
  lrr_pkg::frame_t                   out_frame_r;

  assign adv       = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_frame = out_frame_r;

  always_comb begin
    for (int i = 0; i < lrr_pkg::LANES; i++) begin
      prod_c[i] = $signed(lrr_pkg::PROD_W'(op_diff[i]))
                * $signed(lrr_pkg::PROD_W'({1'b0, issue.frac}));
    end
  end

  // floor by arithmetic shift, then add back the left sample
  always_comb begin
    for (int i = 0; i < lrr_pkg::LANES; i++) begin
      term_c[i] = lrr_pkg::DIFF_W'(s1_prod_r[i] >>> lrr_pkg::FRAC_W);
      sum_c[i]  = lrr_pkg::DIFF_W'(lrr_pkg::sample_t'(s1_a_r[i])) + term_c[i];
      if (lrr_pkg::CHAN_W'(i) < active_channels) begin
        res_c[i] = sum_c[i][lrr_pkg::SAMPLE_W-1:0];
      end else begin
        res_c[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= issue.vld;
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r   <= issue.last;
      s1_a_r      <= op_a;
      s1_prod_r   <= prod_c;
      out_last_r  <= s1_last_r;
      out_frame_r <= res_c;
    end
  end

endmodule

### src/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Push-driven linear interpolation sample rate converter, four lanes.
// ----------------------------------------------------------------------------
// Each input word is one source frame; each output word is one interpolated
// frame, and the final frame caused by an input carries out_last_output. The
// front end takes a new frame whenever the two-word command queue has room,
// so a burst of up to two frames is absorbed while the back end is busy. The
// back end takes a word from the queue in its idle state and then issues the
// output positions of that frame in its run state: N of them for an
// interpolating frame (about 1.0 / rate_step, at most MAX_OUTPUTS_PER_INPUT),
// one for a pass-through frame (rate_step exactly 1.0) and none for a frame
// that yields no output. Unless rate_step is exactly 1.0, the first frame
// after reset only primes the front end. The sequencer, issuing one output
// position per cycle while the output is not stalled, sets the sustained
// rate. Issued positions pass through the multiplier register, then the
// output register; a stall on the output holds both registers and keeps the
// sequencer from issuing. Write the configuration only while the block is idle.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
  parameter int MAX_OUTPUTS_PER_INPUT = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [lrr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lrr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // source frames
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lrr_pkg::SAMPLE_W-1:0]    in_sample_0,
  input  logic [lrr_pkg::SAMPLE_W-1:0]    in_sample_1,
  input  logic [lrr_pkg::SAMPLE_W-1:0]    in_sample_2,
  input  logic [lrr_pkg::SAMPLE_W-1:0]    in_sample_3,
  // interpolated frames
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lrr_pkg::SAMPLE_W-1:0]    out_0,
  output logic [lrr_pkg::SAMPLE_W-1:0]    out_1,
  output logic [lrr_pkg::SAMPLE_W-1:0]    out_2,
  output logic [lrr_pkg::SAMPLE_W-1:0]    out_3,
  output logic                            out_last_output
);

  // Configuration registers
  logic [lrr_pkg::STEP_W-1:0] rate_step_r;
  logic [lrr_pkg::CHAN_W-1:0] active_channels_r;

  // Front end to queue
  lrr_pkg::frame_t in_frame;
  logic            q_push;
  lrr_pkg::cmd_t   q_wdata;
  logic            q_full;

  // Queue to back end
  lrr_pkg::cmd_t   q_rdata;
  logic            q_pop;
  logic            q_empty;

  // Back end to datapath
  lrr_pkg::issue_t issue;
  lrr_pkg::frame_t op_a;
  lrr_pkg::diff_t  op_diff [lrr_pkg::LANES];
  logic            adv;
  lrr_pkg::frame_t out_frame;

  // Take a register write; the step keeps its low 29 bits, the lane count 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_step_r       <= lrr_pkg::RATE_STEP_RST;
      active_channels_r <= lrr_pkg::ACTIVE_CHANNELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrr_pkg::CFG_RATE_STEP: begin
          rate_step_r <= cfg_wdata[lrr_pkg::STEP_W-1:0];
        end
        lrr_pkg::CFG_ACTIVE_CHANNELS: begin
          active_channels_r <= cfg_wdata[lrr_pkg::CHAN_W-1:0];
        end
        default: begin
          rate_step_r <= rate_step_r;
        end
      endcase
    end
  end

  assign in_frame[0] = in_sample_0;
  assign in_frame[1] = in_sample_1;
  assign in_frame[2] = in_sample_2;
  assign in_frame[3] = in_sample_3;

  // Classify: prime, pass through, or interpolate against the stored frame
  lrr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_frame  (in_frame),
    .rate_step (rate_step_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_wdata)
  );

  lrr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Advance the read phase and issue one position per cycle when not stalled
  lrr_back #(
    .MAX_OUTPUTS_PER_INPUT (MAX_OUTPUTS_PER_INPUT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_rdata),
    .q_pop     (q_pop),
    .rate_step (rate_step_r),
    .adv       (adv),
    .issue     (issue),
    .op_a      (op_a),
    .op_diff   (op_diff)
  );

  // a + floor((b - a) * frac / 2^24), lanes beyond the count forced to zero
  lrr_lerp u_lerp (
    .clk             (clk),
    .rst_n           (rst_n),
    .issue           (issue),
    .op_a            (op_a),
    .op_diff         (op_diff),
    .active_channels (active_channels_r),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame       (out_frame),
    .out_last        (out_last_output)
  );

  assign out_0 = out_frame[0];
  assign out_1 = out_frame[1];
  assign out_2 = out_frame[2];
  assign out_3 = out_frame[3];

endmodule
